>>> sv/lru_key_value_cache_assert.svh
// Assertion macros used by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define LKVC_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the clock cycle after its trigger.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

  localparam int unsigned KEY_W            = 32;
  localparam int unsigned VALUE_W          = 64;
  localparam int unsigned CFG_W            = 5;
  localparam int unsigned OCC_W            = 5;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned ADDR_W           = 2;
  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam logic [CFG_W-1:0]  CAP_RESET     = 5'd16;
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_PROBE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_PROMOTE,
    UPD_INSERT,
    UPD_CLEAR
  } upd_e_t;

  typedef struct packed {
    op_e_t              operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             cmp;
    logic [KEY_W-1:0] cmp_key;
    logic             upd_en;
    upd_e_t           mode;
    logic             evict;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> sv/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Input channel in_valid/in_stall/in_data carries one request: get, put,
// probe or clear, with a key and a value. The result channel
// out_valid/out_stall/out_data carries exactly one result per request: hit,
// read value, eviction flag and key, and occupancy after the request.
// Entries sit in a row of cells ordered by recency, most recent first; a
// hit moves its entry to the front and a new key enters at the front while
// the row shifts down by one, dropping the last valid entry on eviction.
// A request is compared against every cell at the edge it transfers and the
// row is updated when the result enters the output register, which waits
// while a stalled result still holds that register. Each request makes a
// compare-then-update pass over the cell row, and a new request is not
// accepted until the previous one has updated the row.
// While the receiver stalls, a finished result holds in the output register;
// one more request may transfer and wait in the compare stage.
// The capacity register (byte address 0) limits the entries in use, zero
// counting as one and values above the row length as the row length.
// Synchronous reset empties the cache and sets capacity to 16; no clearing
// pass is needed.
`default_nettype none
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic              pending_r;
  logic              pending_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CFG_W-1:0]  capacity_r;
  logic [CFG_W-1:0]  capacity_nxt;
  in_item_t          req_r;
  out_item_t         out_data_r;
  out_item_t         result;

  logic              accept;
  logic              apply;
  logic              cfg_write;
  logic              hit;
  logic              evict_now;
  upd_e_t            mode;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  limit;
  logic [VALUE_W-1:0] hit_value;
  logic [KEY_W-1:0]  last_key;
  entry_t            front;
  cell_ctl_t         ctl;

  entry_t            entries [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] below_vec;
  logic [CAPACITY-1:0] last_vec;
  logic [CAPACITY-1:0] valid_vec;

  assign accept    = in_valid & ~in_stall;
  assign in_stall  = pending_r;
  assign apply     = pending_r & (~out_valid_r | ~out_stall);
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity_r) : '0;

  assign cnt_ext = CMP_W'(count_r);
  assign cap_ext = CMP_W'(capacity_r);

  always_comb begin
    priority if (cap_ext == '0) begin
      limit = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      limit = CMP_W'(CAPACITY);
    end else begin
      limit = cap_ext;
    end
  end

  always_comb begin
    hit_value = '0;
    last_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (match_vec[i] ? entries[i].value : '0);
      last_key  = last_key  | (last_vec[i]  ? entries[i].key   : '0);
    end
  end

  assign hit = |match_vec;

  always_comb begin
    mode      = UPD_NONE;
    evict_now = 1'b0;
    count_nxt = count_r;
    result    = '0;
    unique case (req_r.operation)
      OP_GET: begin
        result.hit = hit;
        if (hit) begin
          mode              = UPD_PROMOTE;
          result.read_value = hit_value;
        end
      end
      OP_PUT: begin
        result.hit = hit;
        if (hit) begin
          mode = UPD_PROMOTE;
        end else begin
          mode      = UPD_INSERT;
          evict_now = (cnt_ext >= limit);
          if (evict_now) begin
            result.evicted     = 1'b1;
            result.evicted_key = last_key;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      OP_PROBE: begin
        result.hit = hit;
      end
      OP_CLEAR: begin
        mode      = UPD_CLEAR;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    result.occupancy = OCC_W'(CMP_W'(count_nxt));
  end

  assign front = '{valid: 1'b1,
                   key:   req_r.key,
                   value: (req_r.operation == OP_PUT) ? req_r.value : hit_value};

  assign ctl = '{cmp:     accept,
                 cmp_key: in_data.key,
                 upd_en:  apply,
                 mode:    mode,
                 evict:   evict_now};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_entry;
    logic   below_in;
    logic   succ_valid;

    if (i == 0) begin : g_head
      assign prev_entry = front;
    end else begin : g_body
      assign prev_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign below_in   = 1'b0;
      assign succ_valid = 1'b0;
    end else begin : g_link
      assign below_in   = below_vec[i+1];
      assign succ_valid = valid_vec[i+1];
    end

    lkvc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_entry (prev_entry),
      .below_in   (below_in),
      .succ_valid (succ_valid),
      .entry      (entries[i]),
      .match      (match_vec[i]),
      .below_out  (below_vec[i]),
      .last_valid (last_vec[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  always_comb begin
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    capacity_nxt  = capacity_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (apply) begin
      pending_nxt   = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (accept) begin
      pending_nxt = 1'b1;
    end
    if (cfg_write && (paddr == ADDR_CAPACITY)) begin
      capacity_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      capacity_r  <= capacity_nxt;
      if (apply) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (apply) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "lru_key_value_cache_assert.svh"

  `LKVC_ASSERT_NOW(a_one_match, clk, rst_n, $onehot0(match_vec), "several cells match one key")
  `LKVC_ASSERT_NOW(a_count_valid, clk, rst_n, $countones(valid_vec) == int'(count_r), "entry count differs from valid cells")
  `LKVC_ASSERT_NEXT(a_evict_keeps_count, clk, rst_n, apply && (mode == UPD_INSERT) && evict_now, count_r == $past(count_r), "eviction changed occupancy")

endmodule
`default_nettype wire

>>> sv/lkvc_cell.sv
`default_nettype none
module lkvc_cell import lkvc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    prev_entry,
  input  logic      below_in,
  input  logic      succ_valid,
  output entry_t    entry,
  output logic      match,
  output logic      below_out,
  output logic      last_valid
);

  logic               valid_r;
  logic               valid_nxt;
  logic               match_r;
  logic               match_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic               take;

  always_comb begin
    match_nxt = match_r;
    valid_nxt = valid_r;
    take      = 1'b0;
    if (ctl.cmp) begin
      match_nxt = valid_r && (key_r == ctl.cmp_key);
    end
    if (ctl.upd_en) begin
      unique case (ctl.mode)
        UPD_NONE: begin
        end
        UPD_PROMOTE: begin
          take = below_in | match_r;
          if (take) begin
            valid_nxt = prev_entry.valid;
          end
        end
        UPD_INSERT: begin
          take      = 1'b1;
          valid_nxt = prev_entry.valid & (valid_r | ~ctl.evict);
        end
        UPD_CLEAR: begin
          valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

  assign entry      = '{valid: valid_r, key: key_r, value: value_r};
  assign match      = match_r;
  assign below_out  = below_in | match_r;
  assign last_valid = valid_r & ~succ_valid;

endmodule
`default_nettype wire

>>> tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
module lru_key_value_cache_tb import lkvc_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int MAX_REPORTS = 40;
  localparam int POOL_SIZE   = 32;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } line_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  line_t            lru_order[$];
  out_item_t        replies_due[$];
  logic [CFG_W-1:0] capacity_shadow = CAP_RESET;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  logic             calm = 1'b0;
  int               errors = 0;
  int               results_seen = 0;
  int               hold_left = 0;
  int               cycle_count = 0;

  lru_key_value_cache dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int entries_allowed();
    if (capacity_shadow == 0) return 1;
    if (capacity_shadow > DEFAULT_CAPACITY) return DEFAULT_CAPACITY;
    return int'(capacity_shadow);
  endfunction

  function automatic out_item_t compute_cache_reply(input in_item_t req);
    out_item_t reply;
    line_t     found;
    line_t     fresh;
    int        pos;
    reply = '0;
    pos = -1;
    if (req.operation == OP_CLEAR) begin
      lru_order.delete();
    end else begin
      foreach (lru_order[i]) begin
        if (pos < 0 && lru_order[i].key == req.key) pos = i;
      end
      reply.hit = (pos >= 0);
      if (pos >= 0) found = lru_order[pos];
      case (req.operation)
        OP_GET: begin
          if (pos >= 0) begin
            reply.read_value = found.value;
            lru_order.delete(pos);
            lru_order.push_front(found);
          end
        end
        OP_PUT: begin
          if (pos >= 0) begin
            found.value = req.value;
            lru_order.delete(pos);
            lru_order.push_front(found);
          end else begin
            if (lru_order.size() >= entries_allowed()) begin
              reply.evicted = 1'b1;
              reply.evicted_key = lru_order[$].key;
              void'(lru_order.pop_back());
            end
            fresh.key = req.key;
            fresh.value = req.value;
            lru_order.push_front(fresh);
          end
        end
        default: ;
      endcase
    end
    reply.occupancy = OCC_W'(lru_order.size());
    return reply;
  endfunction

  function automatic in_item_t make_req(input op_e_t op, input logic [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] value);
    in_item_t req;
    req.operation = op;
    req.key = key;
    req.value = value;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (replies_due.size() == 0) begin
      report_mismatch("unexpected result, occupancy", 64'(got.occupancy), 64'd0);
    end else begin
      want = replies_due.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.evicted !== want.evicted)
        report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
      if (got.evicted_key !== want.evicted_key)
        report_mismatch("evicted_key", 64'(got.evicted_key), 64'(want.evicted_key));
      if (got.occupancy !== want.occupancy)
        report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        hold_left = calm ? 0 : $urandom_range(0, 14);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  task automatic send_request(input in_item_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(compute_cache_reply(req));
  endtask

  task automatic settle_cache();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (replies_due.size() != 0) begin
      report_mismatch("results never delivered", 64'(replies_due.size()), 64'd0);
      replies_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    settle_cache();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity_shadow = cap;
    @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_request(make_req(OP_GET, '0, '1));
    send_request(make_req(OP_PUT, '0, '0));
    send_request(make_req(OP_PUT, '1, '1));
    send_request(make_req(OP_GET, '0, '0));
    send_request(make_req(OP_GET, '1, '0));
    send_request(make_req(OP_PROBE, '0, '1));
    send_request(make_req(OP_PROBE, 32'h1234_5678, '0));
    send_request(make_req(OP_PUT, '0, 64'ha5a5_5a5a_c3c3_3c3c));
    send_request(make_req(OP_GET, '0, '0));
    send_request(make_req(OP_CLEAR, '1, '1));
    send_request(make_req(OP_GET, '1, '0));
  endtask

  task automatic test_eviction_order();
    write_capacity(5'd2);
    send_request(make_req(OP_PUT, 32'd1, 64'd11));
    send_request(make_req(OP_PUT, 32'd2, 64'd22));
    send_request(make_req(OP_GET, 32'd1, 64'd0));
    send_request(make_req(OP_PUT, 32'd3, 64'd33));
    send_request(make_req(OP_PROBE, 32'd1, 64'd0));
    send_request(make_req(OP_PUT, 32'd4, 64'd44));
    write_capacity(5'd0);
    send_request(make_req(OP_PUT, 32'd5, 64'd55));
    send_request(make_req(OP_PUT, 32'd6, 64'd66));
    send_request(make_req(OP_GET, 32'd6, 64'd0));
    write_capacity(5'd31);
    send_request(make_req(OP_PUT, 32'd7, 64'd77));
    send_request(make_req(OP_PUT, 32'd8, 64'd88));
    send_request(make_req(OP_GET, 32'd5, 64'd0));
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] cap, input int count,
                                     input int key_span);
    in_item_t req;
    int       pick;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) req.operation = OP_GET;
      else if (pick < 72) req.operation = OP_PUT;
      else if (pick < 97) req.operation = OP_PROBE;
      else req.operation = OP_CLEAR;
      if ($urandom_range(0, 9) == 0) req.key = $urandom;
      else req.key = key_pool[$urandom_range(0, key_span - 1)];
      req.value = {$urandom, $urandom};
      send_request(req);
    end
    calm = 1'b0;
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_eviction_order();
    test_random_traffic(5'd16, 200, 24);
    test_random_traffic(5'd1, 100, 3);
    test_random_traffic(5'd4, 140, 8);
    test_random_traffic(5'd0, 70, 3);
    test_random_traffic(5'd31, 200, 28);
    test_random_traffic(5'd8, 140, 14);
    for (int p = 0; p < 4; p++) test_random_traffic(5'($urandom_range(0, 31)), 50, 20);
    settle_cache();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

endmodule
